@@ sv/orientation_and_shake_detector_top_macros.svh @@
// ----------------------------------------------------------------------------
// Orientation and shake detector assertion macros
// Shared property forms for the checks in the detector RTL.
// ----------------------------------------------------------------------------
`ifndef ORIENTATION_AND_SHAKE_DETECTOR_TOP_MACROS_SVH
`define ORIENTATION_AND_SHAKE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OSD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define OSD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ sv/osd_pkg.sv @@
// ----------------------------------------------------------------------------
// osd_pkg
// Types and constants shared by the orientation and shake detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package osd_pkg;

	typedef enum logic [1:0] {
		OR_LYING    = 2'd0,
		OR_UPRIGHT  = 2'd1,
		OR_INVERTED = 2'd2
	} orient_t;

	localparam logic EV_ORIENT = 1'b0;
	localparam logic EV_SHAKE  = 1'b1;

	typedef enum logic [2:0] {
		REG_UPRIGHT_ENTER  = 3'd0,
		REG_UPRIGHT_EXIT   = 3'd1,
		REG_INVERTED_ENTER = 3'd2,
		REG_INVERTED_EXIT  = 3'd3,
		REG_SHAKE_HIGH     = 3'd4,
		REG_SHAKE_LOW      = 3'd5,
		REG_WINDOW_LEN     = 3'd6,
		REG_COOLDOWN_LEN   = 3'd7
	} reg_idx_t;

	localparam logic signed [15:0] RST_UPRIGHT_ENTER  = 16'sd12000;
	localparam logic signed [15:0] RST_UPRIGHT_EXIT   = 16'sd9000;
	localparam logic signed [15:0] RST_INVERTED_ENTER = -16'sd12000;
	localparam logic signed [15:0] RST_INVERTED_EXIT  = -16'sd9000;
	localparam logic [15:0] RST_SHAKE_HIGH   = 16'd24576;
	localparam logic [15:0] RST_SHAKE_LOW    = 16'd8192;
	localparam logic [15:0] RST_WINDOW_LEN   = 16'd1000;
	localparam logic [15:0] RST_COOLDOWN_LEN = 16'd2000;

	localparam int HIT_CNT_W = 4;

	// event queue geometry (depth is a power of two so pointers wrap freely)
	localparam int EVQ_DEPTH = 8;
	localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
	localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

	typedef struct packed {
		logic    kind;
		orient_t orient;
		logic    last;
	} evt_t;

	typedef struct packed {
		logic v0;
		logic v1;
		evt_t e0;
		evt_t e1;
	} evt_push_t;

	typedef struct packed {
		logic signed [15:0] upright_enter;
		logic signed [15:0] upright_exit;
		logic signed [15:0] inverted_enter;
		logic signed [15:0] inverted_exit;
		logic [15:0]        window_len;
		logic [15:0]        cooldown_len;
	} trk_cfg_t;

endpackage

`default_nettype wire

@@ sv/orientation_and_shake_detector_top.sv @@
// Pipeline: an accepted sample passes the s1 and s2 registers; its events then go into
//   the queue, and the first is offered on the output, one event per transaction.
// Throughput: one sample per cycle through five squaring lanes, one merge stage
//   and the state tracker; in_stall rises only when the 8-entry event queue could overflow.
// Reset: arst_n clears orientation to lying, hit count, window, cooldown and the
//   queue, and loads the default thresholds; no clearing pass is needed.
// ----------------------------------------------------------------------------
// orientation_and_shake_detector_top
// Accelerometer orientation classifier with hysteresis and shake detector.
// ----------------------------------------------------------------------------
`default_nettype none

module orientation_and_shake_detector_top
	import osd_pkg::*;
#(
	parameter int UP_AXIS_IS_Z = 1,
	parameter int HITS_NEEDED  = 3,
	parameter int TIME_WIDTH   = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [15:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [15:0]    accel_x,
	input  wire logic signed [15:0]    accel_y,
	input  wire logic signed [15:0]    accel_z,
	input  wire logic [TIME_WIDTH-1:0] time_ms,
	input  wire logic                  suppress,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       event_kind,
	output logic [1:0]                 orientation,
	output logic                       last
);

	logic signed [15:0] upright_enter_q;
	logic signed [15:0] upright_exit_q;
	logic signed [15:0] inverted_enter_q;
	logic signed [15:0] inverted_exit_q;
	logic [15:0]        shake_high_q;
	logic [15:0]        shake_low_q;
	logic [15:0]        window_len_q;
	logic [15:0]        cooldown_len_q;

	logic                  accept;
	logic                  v_s1, v_s2;
	logic signed [15:0]    up_s1, up_s2;
	logic [TIME_WIDTH-1:0] now_s1, now_s2;
	logic                  sup_s1, sup_s2;

	logic [31:0]           sq_x_s1, sq_y_s1, sq_z_s1, hi_sq_s1, lo_sq_s1;
	logic                  hit_s2;
	trk_cfg_t              trk_cfg;
	evt_push_t             push;
	evt_t                  out_evt;
	logic [EVQ_CNT_W-1:0]  evq_cnt;
	logic [EVQ_CNT_W:0]    load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upright_enter_q  <= RST_UPRIGHT_ENTER;
			upright_exit_q   <= RST_UPRIGHT_EXIT;
			inverted_enter_q <= RST_INVERTED_ENTER;
			inverted_exit_q  <= RST_INVERTED_EXIT;
			shake_high_q     <= RST_SHAKE_HIGH;
			shake_low_q      <= RST_SHAKE_LOW;
			window_len_q     <= RST_WINDOW_LEN;
			cooldown_len_q   <= RST_COOLDOWN_LEN;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_UPRIGHT_ENTER:  upright_enter_q  <= cfg_data;
				REG_UPRIGHT_EXIT:   upright_exit_q   <= cfg_data;
				REG_INVERTED_ENTER: inverted_enter_q <= cfg_data;
				REG_INVERTED_EXIT:  inverted_exit_q  <= cfg_data;
				REG_SHAKE_HIGH:     shake_high_q     <= cfg_data;
				REG_SHAKE_LOW:      shake_low_q      <= cfg_data;
				REG_WINDOW_LEN:     window_len_q     <= cfg_data;
				REG_COOLDOWN_LEN:   cooldown_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall while the queue could not absorb two events for every sample in flight
	always_comb begin
		load = (EVQ_CNT_W + 1)'(evq_cnt) + (EVQ_CNT_W + 1)'({v_s1, 1'b0})
			+ (EVQ_CNT_W + 1)'({v_s2, 1'b0}) + (EVQ_CNT_W + 1)'(2);
		in_stall = load > (EVQ_CNT_W + 1)'(EVQ_DEPTH);
		accept   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		up_s1  <= (UP_AXIS_IS_Z != 0) ? accel_z : accel_y;
		now_s1 <= time_ms;
		sup_s1 <= suppress;
		up_s2  <= up_s1;
		now_s2 <= now_s1;
		sup_s2 <= sup_s1;
	end

	osd_lane u_lane_x  (.clk(clk), .opnd({accel_x[15], accel_x}), .sq_s1(sq_x_s1));
	osd_lane u_lane_y  (.clk(clk), .opnd({accel_y[15], accel_y}), .sq_s1(sq_y_s1));
	osd_lane u_lane_z  (.clk(clk), .opnd({accel_z[15], accel_z}), .sq_s1(sq_z_s1));
	osd_lane u_lane_hi (.clk(clk), .opnd({1'b0, shake_high_q}),   .sq_s1(hi_sq_s1));
	osd_lane u_lane_lo (.clk(clk), .opnd({1'b0, shake_low_q}),    .sq_s1(lo_sq_s1));

	osd_merge u_merge (
		.clk      (clk),
		.sq_x_s1  (sq_x_s1),
		.sq_y_s1  (sq_y_s1),
		.sq_z_s1  (sq_z_s1),
		.hi_sq_s1 (hi_sq_s1),
		.lo_sq_s1 (lo_sq_s1),
		.hit_s2   (hit_s2)
	);

	always_comb begin
		trk_cfg.upright_enter  = upright_enter_q;
		trk_cfg.upright_exit   = upright_exit_q;
		trk_cfg.inverted_enter = inverted_enter_q;
		trk_cfg.inverted_exit  = inverted_exit_q;
		trk_cfg.window_len     = window_len_q;
		trk_cfg.cooldown_len   = cooldown_len_q;
	end

	osd_track #(
		.TW          (TIME_WIDTH),
		.HITS_NEEDED (HITS_NEEDED)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (v_s2),
		.hit_s2   (hit_s2),
		.up_s2    (up_s2),
		.now_s2   (now_s2),
		.sup_s2   (sup_s2),
		.cfg      (trk_cfg),
		.push     (push)
	);

	osd_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_evt   (out_evt),
		.count     (evq_cnt)
	);

	assign event_kind  = out_evt.kind;
	assign orientation = out_evt.orient;
	assign last        = out_evt.last;

endmodule

`default_nettype wire

@@ sv/osd_lane.sv @@
// ----------------------------------------------------------------------------
// osd_lane
// One squaring lane: registered square of a 17-bit signed operand.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_lane (
	input  wire logic               clk,
	input  wire logic signed [16:0] opnd,
	output logic [31:0]             sq_s1
);

	logic signed [33:0] prod;

	assign prod = opnd * opnd;

	// all operands fed here square to below 2^32
	always_ff @(posedge clk) begin
		sq_s1 <= prod[31:0];
	end

endmodule

`default_nettype wire

@@ sv/osd_merge.sv @@
// ----------------------------------------------------------------------------
// osd_merge
// Sums the axis lanes into the squared magnitude and tests it against the
// squared shake bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_merge (
	input  wire logic        clk,
	input  wire logic [31:0] sq_x_s1,
	input  wire logic [31:0] sq_y_s1,
	input  wire logic [31:0] sq_z_s1,
	input  wire logic [31:0] hi_sq_s1,
	input  wire logic [31:0] lo_sq_s1,
	output logic             hit_s2
);

	logic [33:0] mag;
	logic        hit;

	always_comb begin
		mag = 34'(sq_x_s1) + 34'(sq_y_s1) + 34'(sq_z_s1);
		hit = (mag > 34'(hi_sq_s1)) || (mag < 34'(lo_sq_s1));
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit;
	end

endmodule

`default_nettype wire

@@ sv/osd_track.sv @@
// ----------------------------------------------------------------------------
// osd_track
// Orientation hysteresis, cooldown and hit window tracking; produces up to
// two events per sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "orientation_and_shake_detector_top_macros.svh"

module osd_track
	import osd_pkg::*;
#(
	parameter int TW          = 48,
	parameter int HITS_NEEDED = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s2,
	input  wire logic               hit_s2,
	input  wire logic signed [15:0] up_s2,
	input  wire logic [TW-1:0]      now_s2,
	input  wire logic               sup_s2,
	input  wire trk_cfg_t           cfg,
	output evt_push_t               push
);

	orient_t                cur_q;
	logic [HIT_CNT_W-1:0]   cnt_q;
	logic [TW-1:0]          win_start_q;
	logic [TW-1:0]          cool_until_q;
	logic                   armed_q;

	orient_t                nxt_orient;
	logic                   orient_chg;
	logic [TW-1:0]          rem;
	logic [TW-1:0]          age;
	logic                   cooling;
	logic                   run;
	logic                   win_exp;
	logic [HIT_CNT_W-1:0]   cnt_base;
	logic [HIT_CNT_W-1:0]   cnt_inc;
	logic [TW-1:0]          start_base;
	logic                   shake;

	always_comb begin
		case (cur_q)
			OR_UPRIGHT:  nxt_orient = (up_s2 > cfg.upright_exit) ? OR_UPRIGHT : OR_LYING;
			OR_INVERTED: nxt_orient = (up_s2 < cfg.inverted_exit) ? OR_INVERTED : OR_LYING;
			default: begin
				if (up_s2 > cfg.upright_enter)
					nxt_orient = OR_UPRIGHT;
				else if (up_s2 < cfg.inverted_enter)
					nxt_orient = OR_INVERTED;
				else
					nxt_orient = OR_LYING;
			end
		endcase
		orient_chg = (nxt_orient != cur_q);

		// modular differences: counter wrap is harmless
		rem     = cool_until_q - now_s2;
		cooling = armed_q && (rem != '0) && (rem <= TW'(cfg.cooldown_len));
		run     = !cooling && !sup_s2;

		age        = now_s2 - win_start_q;
		win_exp    = age > TW'(cfg.window_len);
		cnt_base   = win_exp ? '0 : cnt_q;
		start_base = win_exp ? now_s2 : win_start_q;
		cnt_inc    = cnt_base + 1'b1;
		shake      = run && hit_s2 && (cnt_inc >= HIT_CNT_W'(HITS_NEEDED));

		// events are packed from slot 0
		push.v0        = valid_s2 && (orient_chg || shake);
		push.v1        = valid_s2 && orient_chg && shake;
		push.e0.kind   = orient_chg ? EV_ORIENT : EV_SHAKE;
		push.e0.orient = nxt_orient;
		push.e0.last   = !(orient_chg && shake);
		push.e1.kind   = EV_SHAKE;
		push.e1.orient = nxt_orient;
		push.e1.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= OR_LYING;
			cnt_q        <= '0;
			win_start_q  <= '0;
			cool_until_q <= '0;
			armed_q      <= 1'b0;
		end else if (valid_s2) begin
			cur_q <= nxt_orient;
			if (run) begin
				if (shake) begin
					cnt_q        <= '0;
					win_start_q  <= now_s2;
					cool_until_q <= now_s2 + TW'(cfg.cooldown_len);
				end else begin
					cnt_q       <= hit_s2 ? cnt_inc : cnt_base;
					win_start_q <= start_base;
				end
			end
			if (shake)
				armed_q <= 1'b1;
			else if (armed_q && !cooling)
				armed_q <= 1'b0;
		end
	end

	`OSD_ASSERT_NOW(a_cnt_below_target, clk, arst_n, 1'b1,
		cnt_q < HIT_CNT_W'(HITS_NEEDED))
	`OSD_ASSERT_NEXT(a_shake_arms_cooldown, clk, arst_n, valid_s2 && shake, armed_q)
	`OSD_ASSERT_NOW(a_last_marks_final, clk, arst_n, push.v0,
		(push.e0.last == !push.v1) && (!push.v1 || push.e0.kind == EV_ORIENT))

endmodule

`default_nettype wire

@@ sv/osd_evq.sv @@
// ----------------------------------------------------------------------------
// osd_evq
// Event queue: takes up to two events per cycle, hands out one per
// transaction on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "orientation_and_shake_detector_top_macros.svh"

module osd_evq
	import osd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire evt_push_t       push,
	input  wire logic            out_stall,
	output logic                 out_valid,
	output evt_t                 out_evt,
	output logic [EVQ_CNT_W-1:0] count
);

	evt_t                 mem_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0] wr_ptr_q;
	logic [EVQ_PTR_W-1:0] rd_ptr_q;
	logic [EVQ_CNT_W-1:0] cnt_q;

	logic                 pop;
	logic [1:0]           n_push;
	logic [EVQ_CNT_W:0]   fill_chk;

	always_comb begin
		out_valid = (cnt_q != '0);
		out_evt   = mem_q[rd_ptr_q];
		count     = cnt_q;
		pop       = out_valid && !out_stall;
		n_push    = 2'(push.v0) + 2'(push.v1);
		fill_chk  = (EVQ_CNT_W + 1)'(cnt_q) + (EVQ_CNT_W + 1)'(n_push);
	end

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_ptr_q] <= push.e0;
		if (push.v1)
			mem_q[wr_ptr_q + 1'b1] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + EVQ_CNT_W'(n_push) - EVQ_CNT_W'(pop);
		end
	end

	`OSD_ASSERT_NOW(a_cnt_in_range, clk, arst_n, 1'b1, cnt_q <= EVQ_CNT_W'(EVQ_DEPTH))
	`OSD_ASSERT_NOW(a_no_overflow, clk, arst_n, push.v0 || push.v1,
		fill_chk <= (EVQ_CNT_W + 1)'(EVQ_DEPTH))
	`OSD_ASSERT_NOW(a_slots_packed, clk, arst_n, push.v1, push.v0)

endmodule

`default_nettype wire

@@ verif/orientation_and_shake_detector_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orientation_and_shake_detector_top_tb
// Self-checking bench for the orientation and shake detector. A driver feeds
// samples from a queue in random bursts. The accepted samples go through a
// local model of the classifier and shake tracker. A monitor compares each
// output transaction with the oldest predicted event while the receiver
// stalls on its own random pattern.
// ----------------------------------------------------------------------------

module orientation_and_shake_detector_top_tb;
	import osd_pkg::*;

	localparam int UP_Z           = 1;
	localparam int HITS_TARGET    = 3;
	localparam int TW             = 48;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [TW-1:0]      t_ms;
		logic               sup;
	} sample_t;

	typedef struct {
		logic signed [15:0] up_enter;
		logic signed [15:0] up_exit;
		logic signed [15:0] inv_enter;
		logic signed [15:0] inv_exit;
		logic [15:0]        hi_bound;
		logic [15:0]        lo_bound;
		logic [15:0]        win_len;
		logic [15:0]        cool_len;
	} thr_cfg_t;

	typedef enum {SEQ_SHAKE, SEQ_TILT, SEQ_CALM, SEQ_NOISE} seq_kind_t;
	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = REG_UPRIGHT_ENTER;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic [TW-1:0]      time_ms = '0;
	logic               suppress = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               event_kind;
	logic [1:0]         orientation;
	logic               last;

	// model state
	thr_cfg_t             cfg_now;
	orient_t              pose;
	logic [HIT_CNT_W-1:0] hit_cnt;
	logic [TW-1:0]        win_start;
	logic [TW-1:0]        cool_until;
	logic                 cool_armed;

	sample_t       sample_q[$];
	evt_t          pending_events[$];
	logic [TW-1:0] now_ms = '0;
	int            phase_no = 0;
	int            errors = 0;
	int            cycles = 0;

	orientation_and_shake_detector_top #(
		.UP_AXIS_IS_Z(UP_Z),
		.HITS_NEEDED (HITS_TARGET),
		.TIME_WIDTH  (TW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.time_ms    (time_ms),
		.suppress   (suppress),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.orientation(orientation),
		.last       (last)
	);

	always #6 clk = ~clk;

	function automatic orient_t classify(input logic signed [15:0] up);
		case (pose)
			OR_UPRIGHT:  return (up > cfg_now.up_exit) ? OR_UPRIGHT : OR_LYING;
			OR_INVERTED: return (up < cfg_now.inv_exit) ? OR_INVERTED : OR_LYING;
			default: begin
				if (up > cfg_now.up_enter)
					return OR_UPRIGHT;
				if (up < cfg_now.inv_enter)
					return OR_INVERTED;
				return OR_LYING;
			end
		endcase
	endfunction

	task automatic predict_events(input sample_t s);
		orient_t            nxt;
		logic signed [15:0] up;
		logic               moved;
		logic               shaken;
		logic               cooling;
		logic               hit;
		longint             mag;
		longint             hi_sq;
		longint             lo_sq;
		logic [TW-1:0]      rem;
		logic [TW-1:0]      age;
		evt_t               ev;
		up = UP_Z ? s.az : s.ay;
		nxt = classify(up);
		moved = (nxt != pose);
		pose = nxt;
		shaken = 1'b0;
		cooling = 1'b0;
		if (cool_armed) begin
			rem = cool_until - s.t_ms;
			if (rem != '0 && rem <= TW'(cfg_now.cool_len))
				cooling = 1'b1;
			else
				cool_armed = 1'b0;
		end
		if (!cooling && !s.sup) begin
			mag = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
			hi_sq = longint'(cfg_now.hi_bound) * cfg_now.hi_bound;
			lo_sq = longint'(cfg_now.lo_bound) * cfg_now.lo_bound;
			hit = (mag > hi_sq) || (mag < lo_sq);
			age = s.t_ms - win_start;
			// window restarts before the hit is counted
			if (age > TW'(cfg_now.win_len)) begin
				win_start = s.t_ms;
				hit_cnt = '0;
			end
			if (hit) begin
				hit_cnt = hit_cnt + 1'b1;
				if (hit_cnt >= HITS_TARGET) begin
					hit_cnt = '0;
					win_start = s.t_ms;
					cool_until = s.t_ms + TW'(cfg_now.cool_len);
					cool_armed = 1'b1;
					shaken = 1'b1;
				end
			end
		end
		if (moved) begin
			ev.kind = EV_ORIENT;
			ev.orient = pose;
			ev.last = !shaken;
			pending_events.push_back(ev);
		end
		if (shaken) begin
			ev.kind = EV_SHAKE;
			ev.orient = pose;
			ev.last = 1'b1;
			pending_events.push_back(ev);
		end
	endtask

	// driver: one transaction per accepted sample, bursts with random gaps
	sample_t next_item;
	sample_t taken_item;
	int      burst_left = 1;
	int      gap_left = 0;
	logic    valid_nxt;

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			taken_item.ax = accel_x;
			taken_item.ay = accel_y;
			taken_item.az = accel_z;
			taken_item.t_ms = time_ms;
			taken_item.sup = suppress;
			predict_events(taken_item);
		end
		if (arst_n && (!in_valid || !in_stall)) begin
			valid_nxt = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (sample_q.size() > 0) begin
				next_item = sample_q.pop_front();
				accel_x <= next_item.ax;
				accel_y <= next_item.ay;
				accel_z <= next_item.az;
				time_ms <= next_item.t_ms;
				suppress <= next_item.sup;
				valid_nxt = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			in_valid <= valid_nxt;
		end
	end

	// receiver stall pattern, with one long hold-off in the pressure phase
	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 0;
	int       rx_tick = 0;
	int       hold_left = 0;
	logic     hold_used = 1'b0;
	logic     stall_nxt;

	always @(posedge clk) begin
		if (phase_no == PRESSURE_PHASE && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_nxt = 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 150);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE:  stall_nxt = 1'b0;
				RX_LIGHT: stall_nxt = ($urandom_range(0, 3) == 0);
				RX_HEAVY: stall_nxt = ($urandom_range(0, 3) != 0);
				default:  stall_nxt = (rx_tick % 5) < 2;
			endcase
		end
		out_stall <= stall_nxt;
	end

	// monitor
	evt_t want;

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_kind %0d orientation %0d last %0d",
					event_kind, orientation, last);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
					errors++;
				end
				if (orientation !== 2'(want.orient)) begin
					$error("orientation: expected %0d, actual %0d", want.orient, orientation);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int sat16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand_signed(input int lo, input int hi);
		int m;
		m = $urandom_range(lo, hi);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// x component that puts the vector midway between the shake bounds
	function automatic int calm_side(input int z);
		int  m;
		real q;
		m = (int'(cfg_now.lo_bound) + int'(cfg_now.hi_bound)) / 2;
		q = real'(m) * real'(m) - real'(z) * real'(z);
		if (q <= 0.0)
			return 0;
		return sat16(int'($sqrt(q)));
	endfunction

	function automatic int near_threshold();
		logic signed [15:0] thr;
		case ($urandom_range(0, 3))
			0:       thr = cfg_now.up_enter;
			1:       thr = cfg_now.up_exit;
			2:       thr = cfg_now.inv_enter;
			default: thr = cfg_now.inv_exit;
		endcase
		return sat16(int'(thr) + int'($urandom_range(0, 4)) - 2);
	endfunction

	function automatic thr_cfg_t random_config();
		thr_cfg_t c;
		int       e;
		if ($urandom_range(0, 3) != 0) begin
			e = $urandom_range(4000, 20000);
			c.up_enter = 16'(e);
			c.up_exit = 16'(e - int'($urandom_range(0, 6000)));
			e = $urandom_range(4000, 20000);
			c.inv_enter = 16'(-e);
			c.inv_exit = 16'(-e + int'($urandom_range(0, 6000)));
		end else begin
			c.up_enter = 16'($urandom);
			c.up_exit = 16'($urandom);
			c.inv_enter = 16'($urandom);
			c.inv_exit = 16'($urandom);
		end
		if ($urandom_range(0, 3) != 0) begin
			c.hi_bound = 16'($urandom_range(18000, 40000));
			c.lo_bound = 16'($urandom_range(0, 16000));
		end else begin
			c.hi_bound = 16'($urandom);
			c.lo_bound = 16'($urandom);
		end
		c.win_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
		c.cool_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		return c;
	endfunction

	task automatic queue_sample(input int x, input int y, input int z,
			input logic [TW-1:0] t, input logic sup);
		sample_t s;
		s.ax = 16'(x);
		s.ay = 16'(y);
		s.az = 16'(z);
		s.t_ms = t;
		s.sup = sup;
		now_ms = t;
		sample_q.push_back(s);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_UPRIGHT_ENTER:  cfg_now.up_enter = val;
			REG_UPRIGHT_EXIT:   cfg_now.up_exit = val;
			REG_INVERTED_ENTER: cfg_now.inv_enter = val;
			REG_INVERTED_EXIT:  cfg_now.inv_exit = val;
			REG_SHAKE_HIGH:     cfg_now.hi_bound = val;
			REG_SHAKE_LOW:      cfg_now.lo_bound = val;
			REG_WINDOW_LEN:     cfg_now.win_len = val;
			default:            cfg_now.cool_len = val;
		endcase
	endtask

	task automatic apply_config(input thr_cfg_t c);
		write_reg(REG_UPRIGHT_ENTER, c.up_enter);
		write_reg(REG_UPRIGHT_EXIT, c.up_exit);
		write_reg(REG_INVERTED_ENTER, c.inv_enter);
		write_reg(REG_INVERTED_EXIT, c.inv_exit);
		write_reg(REG_SHAKE_HIGH, c.hi_bound);
		write_reg(REG_SHAKE_LOW, c.lo_bound);
		write_reg(REG_WINDOW_LEN, c.win_len);
		write_reg(REG_COOLDOWN_LEN, c.cool_len);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		#1;
	endtask

	// samples with no event may still be in flight once the queue empties
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (sample_q.size() != 0 || in_valid || pending_events.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
	endtask

	// runs against the reset thresholds
	task automatic queue_directed();
		queue_sample(16384, 0, 0, 10, 1'b0);
		// entry and exit thresholds, one count either side
		queue_sample(12000, 0, 12000, 20, 1'b0);
		queue_sample(12000, 0, 12001, 30, 1'b0);
		queue_sample(12000, 0, 9001, 40, 1'b0);
		queue_sample(12000, 0, 9000, 50, 1'b0);
		queue_sample(12000, 0, -12000, 60, 1'b0);
		queue_sample(12000, 0, -12001, 70, 1'b0);
		queue_sample(12000, 0, -9001, 80, 1'b0);
		queue_sample(12000, 0, -9000, 90, 1'b0);
		// full-scale axes, suppressed hit, then orientation change plus shake
		queue_sample(-32768, -32768, -32768, 100, 1'b0);
		queue_sample(32767, 32767, 32767, 200, 1'b1);
		queue_sample(32767, 32767, 32767, 300, 1'b0);
		queue_sample(0, 0, 0, 400, 1'b0);
		// cooldown, its end, window restart just past its length
		queue_sample(0, 0, 0, 500, 1'b0);
		queue_sample(0, 0, 0, 2400, 1'b0);
		queue_sample(0, 0, 0, 3401, 1'b0);
		queue_sample(0, 0, 0, 4401, 1'b0);
		queue_sample(0, 100, 0, 4402, 1'b0);
		queue_sample(0, 0, 0, 6401, 1'b0);
		queue_sample(0, 0, 0, 6402, 1'b0);
		// magnitude exactly on each bound is not a hit
		queue_sample(24576, 0, 0, 6500, 1'b0);
		queue_sample(8192, 0, 0, 6600, 1'b0);
		queue_sample(24577, 0, 0, 6700, 1'b0);
		queue_sample(8191, 0, 0, 6800, 1'b0);
	endtask

	// every sample flips orientation, so events pile up behind the hold-off
	task automatic queue_pressure();
		for (int i = 0; i < 80; i++)
			queue_sample(0, 0, (i % 2 == 0) ? 30000 : -30000, now_ms + 1, 1'b1);
	endtask

	task automatic queue_random(input int count);
		seq_kind_t     kind;
		int            len;
		int            pick;
		int            x;
		int            y;
		int            z;
		logic [TW-1:0] step;
		logic          sup;
		while (count > 0) begin
			pick = $urandom_range(0, 99);
			kind = (pick < 45) ? SEQ_SHAKE : (pick < 70) ? SEQ_TILT :
				(pick < 85) ? SEQ_CALM : SEQ_NOISE;
			len = $urandom_range(2, 6);
			for (int i = 0; i < len; i++) begin
				sup = ($urandom_range(0, 11) == 0);
				step = TW'($urandom_range(0, 400));
				case (kind)
					SEQ_SHAKE: begin
						step = TW'($urandom_range(0, cfg_now.win_len / 2 + 1));
						if ($urandom_range(0, 1)) begin
							x = rand_signed(20000, 32767);
							y = rand_signed(20000, 32767);
							z = rand_signed(20000, 32767);
						end else begin
							x = rand_signed(0, 3000);
							y = rand_signed(0, 3000);
							z = rand_signed(0, 3000);
						end
					end
					SEQ_TILT: begin
						z = near_threshold();
						x = calm_side(z);
						y = rand_signed(0, 200);
					end
					SEQ_CALM: begin
						z = int'($urandom_range(0, 40000)) - 20000;
						x = calm_side(z);
						y = rand_signed(0, 500);
					end
					default: begin
						x = $urandom;
						y = $urandom;
						z = $urandom;
						sup = 1'($urandom_range(0, 1));
						if ($urandom_range(0, 3) == 0)
							step = TW'({$urandom, $urandom}) >> $urandom_range(0, TW - 1);
					end
				endcase
				queue_sample(x, y, z, now_ms + step, sup);
			end
			count -= len;
		end
	endtask

	initial begin
		thr_cfg_t dflt_cfg;
		thr_cfg_t cfg_pick;
		dflt_cfg = '{RST_UPRIGHT_ENTER, RST_UPRIGHT_EXIT, RST_INVERTED_ENTER,
			RST_INVERTED_EXIT, RST_SHAKE_HIGH, RST_SHAKE_LOW, RST_WINDOW_LEN,
			RST_COOLDOWN_LEN};
		cfg_now = dflt_cfg;
		pose = OR_LYING;
		hit_cnt = '0;
		win_start = '0;
		cool_until = '0;
		cool_armed = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		phase_no = 1;
		queue_directed();
		wait_drained();

		// nothing can change orientation or hit
		phase_no = 2;
		cfg_pick = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
			16'h0000, 16'h0000};
		apply_config(cfg_pick);
		queue_random(60);
		wait_drained();

		// every sample hits, orientation toggles, longest window and cooldown
		phase_no = 3;
		cfg_pick = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
			16'hFFFF, 16'hFFFF};
		apply_config(cfg_pick);
		queue_random(150);
		wait_drained();

		phase_no = PRESSURE_PHASE;
		apply_config(dflt_cfg);
		queue_pressure();
		wait_drained();

		// timestamps cross the 48-bit wrap
		phase_no = 5;
		now_ms = {TW{1'b1}} - TW'(1023);
		queue_random(100);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			phase_no = 6 + p;
			apply_config(random_config());
			queue_random(150);
			wait_drained();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/osd_pkg.sv
sv/osd_lane.sv
sv/osd_merge.sv
sv/osd_track.sv
sv/osd_evq.sv
sv/orientation_and_shake_detector_top.sv
verif/orientation_and_shake_detector_top_tb.sv
